// ----- design/cde_pkg.sv -----
`timescale 1ns / 1ps

package cde_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;

    // command codes, codes above query also act as query
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_dp_ctrl;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ----- design/cde_intf.sv -----
`timescale 1ns / 1ps

interface cde_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [cde_pkg::CMD_W-1:0]            cmd;
    logic signed [cde_pkg::DATA_W-1:0]    value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface cde_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [cde_pkg::STATUS_W-1:0]         status;
    logic signed [cde_pkg::DATA_W-1:0]    front_value;
    logic signed [cde_pkg::DATA_W-1:0]    rear_value;
    logic                                 is_empty;
    logic                                 is_full;

    modport source (output valid, output status, output front_value, output rear_value,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input status, input front_value, input rear_value,
                    input is_empty, input is_full, output ready);
endinterface

// ----- design/cde_ctrl.sv -----
`timescale 1ns / 1ps

module cde_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  cde_pkg::t_dp_status   i_status,
    output cde_pkg::t_dp_ctrl     o_ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_LOAD
    } t_state;

    t_state r_state;
    logic   r_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    // ready rises in the cycle after reset is released
                    if (!r_in_ready) begin
                        r_in_ready <= 1'b1;
                    end else if (i_in_valid) begin
                        r_state    <= S_EXEC;
                        r_in_ready <= 1'b0;
                    end
                end
                S_EXEC: begin
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (i_status.out_free) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_ready     = r_in_ready;
    assign o_ctrl.capture = i_in_valid && r_in_ready;
    assign o_ctrl.exec    = (r_state == S_EXEC);
    assign o_ctrl.load    = (r_state == S_LOAD) && i_status.out_free;

endmodule

// ----- design/cde_dpath.sv -----
`timescale 1ns / 1ps

module cde_dpath #(
    parameter int DEPTH = cde_pkg::DEPTH_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cde_pkg::t_dp_ctrl                  i_ctrl,
    output cde_pkg::t_dp_status                o_status,
    input  logic [cde_pkg::CMD_W-1:0]          i_cmd,
    input  logic signed [cde_pkg::DATA_W-1:0]  i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [cde_pkg::STATUS_W-1:0]       o_status_code,
    output logic signed [cde_pkg::DATA_W-1:0]  o_front_value,
    output logic signed [cde_pkg::DATA_W-1:0]  o_rear_value,
    output logic                               o_is_empty,
    output logic                               o_is_full
);

    localparam int             IW   = $clog2(DEPTH);
    localparam logic [IW-1:0]  LAST = IW'(DEPTH - 1);

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
        return (i == LAST) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
        return (i == '0) ? LAST : i - 1'b1;
    endfunction

    logic [cde_pkg::CMD_W-1:0]          r_cmd;
    logic signed [cde_pkg::DATA_W-1:0]  r_value;
    logic [IW-1:0]                      r_head, n_head;
    logic [IW-1:0]                      r_tail, n_tail;
    logic                               r_empty, n_empty;
    logic [cde_pkg::STATUS_W-1:0]       r_status, n_status;

    logic signed [cde_pkg::DATA_W-1:0]  r_mem [DEPTH];
    logic signed [cde_pkg::DATA_W-1:0]  r_rd_front;
    logic signed [cde_pkg::DATA_W-1:0]  r_rd_rear;
    logic                               w_we;
    logic [IW-1:0]                      w_waddr;
    logic                               w_full;

    logic                               r_out_valid;
    logic [cde_pkg::STATUS_W-1:0]       r_out_status;
    logic signed [cde_pkg::DATA_W-1:0]  r_out_front;
    logic signed [cde_pkg::DATA_W-1:0]  r_out_rear;
    logic                               r_out_empty;
    logic                               r_out_full;

    assign w_full = !r_empty && (idx_inc(r_tail) == r_head);

    // step the indices for the captured command
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_empty  = r_empty;
        n_status = cde_pkg::ST_DONE;
        w_we     = 1'b0;
        w_waddr  = r_head;
        unique case (r_cmd)
            cde_pkg::CMD_PUSH_FRONT, cde_pkg::CMD_PUSH_BACK: begin
                if (w_full) begin
                    n_status = cde_pkg::ST_PUSH_FULL;
                end else if (r_empty) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b0;
                    w_we    = 1'b1;
                    w_waddr = '0;
                end else if (r_cmd == cde_pkg::CMD_PUSH_FRONT) begin
                    n_head  = idx_dec(r_head);
                    w_we    = 1'b1;
                    w_waddr = idx_dec(r_head);
                end else begin
                    n_tail  = idx_inc(r_tail);
                    w_we    = 1'b1;
                    w_waddr = idx_inc(r_tail);
                end
            end
            cde_pkg::CMD_POP_FRONT, cde_pkg::CMD_POP_BACK: begin
                if (r_empty) begin
                    n_status = cde_pkg::ST_POP_EMPTY;
                end else if (r_head == r_tail) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b1;
                end else if (r_cmd == cde_pkg::CMD_POP_FRONT) begin
                    n_head = idx_inc(r_head);
                end else begin
                    n_tail = idx_dec(r_tail);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else if (i_ctrl.exec) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd   <= i_cmd;
            r_value <= i_value;
        end
        if (i_ctrl.exec) begin
            r_status <= n_status;
        end
    end

    // ring memory, one write port and two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec && w_we) begin
            r_mem[w_waddr] <= r_value;
        end
        r_rd_front <= r_mem[r_head];
        r_rd_rear  <= r_mem[r_tail];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_out_status <= r_status;
            r_out_front  <= r_empty ? '0 : r_rd_front;
            r_out_rear   <= r_empty ? '0 : r_rd_rear;
            r_out_empty  <= r_empty;
            r_out_full   <= w_full;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status_code = r_out_status;
    assign o_front_value = r_out_front;
    assign o_rear_value  = r_out_rear;
    assign o_is_empty    = r_out_empty;
    assign o_is_full     = r_out_full;

endmodule

// ----- design/circular_deque_engine.sv -----
`timescale 1ns / 1ps
// latency: an accepted word passes the exec, read and load states; the result word
//   is valid once load finds the output free, so a stalled output delays it; a new
//   word is taken only after that load; exec writes the ring, read registers it
// reset: i_rst_n synchronous, active low; clears head, tail, empty flag and valids
// input ready is low during reset and rises in the cycle after reset is released
// the ring memory is not cleared, only entries already written ever reach the result

module circular_deque_engine #(
    parameter int DEPTH = cde_pkg::DEPTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cde_in_if.sink        i_in,
    cde_out_if.source     o_out
);

    // command and status between sequencer and datapath
    cde_pkg::t_dp_ctrl    w_ctrl;
    cde_pkg::t_dp_status  w_status;

    // sequencer: idle -> exec (index step and write) -> read -> load result
    // a new word is taken while the previous result still waits on the output
    cde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_ctrl     (w_ctrl)
    );

    // datapath: head/tail indices, empty flag, ring memory and result register
    cde_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .o_status      (w_status),
        .i_cmd         (i_in.cmd),
        .i_value       (i_in.value),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_status_code (o_out.status),
        .o_front_value (o_out.front_value),
        .o_rear_value  (o_out.rear_value),
        .o_is_empty    (o_out.is_empty),
        .o_is_full     (o_out.is_full)
    );

endmodule

// ----- verif/circular_deque_engine_test.sv -----
`timescale 1ns / 1ps

module circular_deque_engine_test;

    localparam int DEPTH = cde_pkg::DEPTH_DEFAULT;
    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [cde_pkg::CMD_W-1:0] CMD_CODE_MAX = '1;
    localparam logic signed [cde_pkg::DATA_W-1:0] WORD_MIN =
        {1'b1, {(cde_pkg::DATA_W-1){1'b0}}};
    localparam logic signed [cde_pkg::DATA_W-1:0] WORD_MAX =
        {1'b0, {(cde_pkg::DATA_W-1){1'b1}}};
    localparam int TARGET_WORDS = 650;
    localparam int SETTLE_CYCLES = 12;

    typedef struct {
        logic [cde_pkg::CMD_W-1:0]          cmd;
        logic signed [cde_pkg::DATA_W-1:0]  value;
        bit                                 hold_until_drained;
    } t_deque_op;

    typedef struct {
        logic [cde_pkg::STATUS_W-1:0]       status;
        logic signed [cde_pkg::DATA_W-1:0]  front_value;
        logic signed [cde_pkg::DATA_W-1:0]  rear_value;
        logic                               is_empty;
        logic                               is_full;
    } t_deque_view;

    logic i_clk;
    logic i_rst_n;

    cde_in_if  in_if ();
    cde_out_if out_if ();

    circular_deque_engine #(.DEPTH(DEPTH)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // shadow deque state
    logic signed [cde_pkg::DATA_W-1:0] deque_words [DEPTH];
    logic [IDX_W-1:0]                  head_pos;
    logic [IDX_W-1:0]                  tail_pos;
    logic                              deque_empty;

    t_deque_op   pending_ops [$];
    t_deque_view expected_views [$];
    int          error_count;
    int          words_checked;
    int          send_gap;
    int          send_calm;
    int          recv_stall;
    int          recv_calm;

    function automatic logic [IDX_W-1:0] ring_next(logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ring_prev(logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    // applies one command to the shadow deque and returns the view after it
    function automatic t_deque_view deque_apply(logic [cde_pkg::CMD_W-1:0] cmd,
                                                logic signed [cde_pkg::DATA_W-1:0] word);
        t_deque_view v;
        logic        was_full;
        was_full = !deque_empty && (ring_next(tail_pos) == head_pos);
        v.status = cde_pkg::ST_DONE;
        case (cmd)
            cde_pkg::CMD_PUSH_FRONT, cde_pkg::CMD_PUSH_BACK: begin
                if (was_full) begin
                    v.status = cde_pkg::ST_PUSH_FULL;
                end else if (deque_empty) begin
                    head_pos       = '0;
                    tail_pos       = '0;
                    deque_empty    = 1'b0;
                    deque_words[0] = word;
                end else if (cmd == cde_pkg::CMD_PUSH_FRONT) begin
                    head_pos              = ring_prev(head_pos);
                    deque_words[head_pos] = word;
                end else begin
                    tail_pos              = ring_next(tail_pos);
                    deque_words[tail_pos] = word;
                end
            end
            cde_pkg::CMD_POP_FRONT, cde_pkg::CMD_POP_BACK: begin
                if (deque_empty) begin
                    v.status = cde_pkg::ST_POP_EMPTY;
                end else if (head_pos == tail_pos) begin
                    head_pos    = '0;
                    tail_pos    = '0;
                    deque_empty = 1'b1;
                end else if (cmd == cde_pkg::CMD_POP_FRONT) begin
                    head_pos = ring_next(head_pos);
                end else begin
                    tail_pos = ring_prev(tail_pos);
                end
            end
            default: ;
        endcase
        v.front_value = deque_empty ? '0 : deque_words[head_pos];
        v.rear_value  = deque_empty ? '0 : deque_words[tail_pos];
        v.is_empty    = deque_empty;
        v.is_full     = !deque_empty && (ring_next(tail_pos) == head_pos);
        return v;
    endfunction

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [cde_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(logic [cde_pkg::CMD_W-1:0] cmd,
                            logic signed [cde_pkg::DATA_W-1:0] value,
                            bit hold = 1'b0);
        t_deque_op op;
        op.cmd                = cmd;
        op.value              = value;
        op.hold_until_drained = hold;
        pending_ops.push_back(op);
    endtask

    task automatic report_mismatch(string field, logic [cde_pkg::DATA_W-1:0] want,
                                   logic [cde_pkg::DATA_W-1:0] got);
        if (error_count < 50)
            $display("mismatch on %s, result word %0d: expected %0h got %0h",
                     field, words_checked, want, got);
        error_count++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // driver: one pending word is held on the bus until it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.cmd   <= cde_pkg::CMD_QUERY;
            in_if.value <= '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                expected_views.push_back(deque_apply(in_if.cmd, in_if.value));
                pending_ops.pop_front();
            end
            if (!in_if.valid || in_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_if.valid <= 1'b0;
                end else if (pending_ops.size() > 0 &&
                             !(pending_ops[0].hold_until_drained &&
                               expected_views.size() > 0)) begin
                    in_if.valid <= 1'b1;
                    in_if.cmd   <= pending_ops[0].cmd;
                    in_if.value <= pending_ops[0].value;
                    send_gap = (send_calm > 0) ? 0 : pick_idle();
                    if (send_calm > 0) send_calm--;
                    else if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 40);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result word against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_views.size() == 0) begin
                    if (error_count < 50)
                        $display("unexpected result word %0d", words_checked);
                    error_count++;
                end else begin
                    if (out_if.status !== expected_views[0].status)
                        report_mismatch("status",
                                        cde_pkg::DATA_W'(expected_views[0].status),
                                        cde_pkg::DATA_W'(out_if.status));
                    if (out_if.front_value !== expected_views[0].front_value)
                        report_mismatch("front_value", expected_views[0].front_value,
                                        out_if.front_value);
                    if (out_if.rear_value !== expected_views[0].rear_value)
                        report_mismatch("rear_value", expected_views[0].rear_value,
                                        out_if.rear_value);
                    if (out_if.is_empty !== expected_views[0].is_empty)
                        report_mismatch("is_empty",
                                        cde_pkg::DATA_W'(expected_views[0].is_empty),
                                        cde_pkg::DATA_W'(out_if.is_empty));
                    if (out_if.is_full !== expected_views[0].is_full)
                        report_mismatch("is_full",
                                        cde_pkg::DATA_W'(expected_views[0].is_full),
                                        cde_pkg::DATA_W'(out_if.is_full));
                    expected_views.pop_front();
                end
                words_checked++;
                recv_stall = (recv_calm > 0) ? 0 : pick_idle();
                if (recv_calm > 0) recv_calm--;
                else if ($urandom_range(0, 49) == 0) recv_calm = $urandom_range(20, 40);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int push_pct;
        int pop_pct;
        int run_len;
        int r;
        logic [cde_pkg::CMD_W-1:0] cmd;

        i_rst_n      = 1'b0;
        head_pos     = '0;
        tail_pos     = '0;
        deque_empty  = 1'b1;
        error_count  = 0;
        words_checked = 0;
        send_gap     = 0;
        send_calm    = 0;
        recv_stall   = 0;
        recv_calm    = 0;

        // directed: empty deque, rejected pops, pushes into empty, last pop, unused codes
        queue_op(cde_pkg::CMD_QUERY, '0);
        queue_op(cde_pkg::CMD_POP_FRONT, '0);
        queue_op(cde_pkg::CMD_POP_BACK, '0);
        queue_op(cde_pkg::CMD_PUSH_BACK, WORD_MAX);
        queue_op(cde_pkg::CMD_POP_FRONT, '0);
        queue_op(cde_pkg::CMD_PUSH_FRONT, WORD_MIN);
        queue_op(cde_pkg::CMD_PUSH_FRONT, '0);
        queue_op(cde_pkg::CMD_PUSH_BACK, '1);
        queue_op(cde_pkg::CMD_POP_BACK, '0);
        queue_op(cde_pkg::CMD_POP_FRONT, '0);
        queue_op(cde_pkg::CMD_POP_BACK, '0);
        for (int c = cde_pkg::CMD_QUERY + 1; c <= CMD_CODE_MAX; c++)
            queue_op(cde_pkg::CMD_W'(c), '1);
        // fill past full, then drain past empty, both ends mixed
        for (int i = 0; i < DEPTH + 3; i++)
            queue_op($urandom_range(0, 1) ? cde_pkg::CMD_PUSH_FRONT : cde_pkg::CMD_PUSH_BACK,
                     pick_word(), i == 0);
        for (int i = 0; i < DEPTH + 3; i++)
            queue_op($urandom_range(0, 1) ? cde_pkg::CMD_POP_FRONT : cde_pkg::CMD_POP_BACK,
                     pick_word());

        // random runs that lean toward filling, draining or neither
        while (pending_ops.size() < TARGET_WORDS) begin
            case ($urandom_range(0, 2))
                0:       begin push_pct = 80; pop_pct = 15; end
                1:       begin push_pct = 15; pop_pct = 80; end
                default: begin push_pct = 45; pop_pct = 45; end
            endcase
            run_len = $urandom_range(10, 50);
            for (int i = 0; i < run_len; i++) begin
                r = $urandom_range(0, 99);
                if (r < push_pct)
                    cmd = $urandom_range(0, 1) ? cde_pkg::CMD_PUSH_FRONT
                                               : cde_pkg::CMD_PUSH_BACK;
                else if (r < push_pct + pop_pct)
                    cmd = $urandom_range(0, 1) ? cde_pkg::CMD_POP_FRONT
                                               : cde_pkg::CMD_POP_BACK;
                else if ($urandom_range(0, 1))
                    cmd = cde_pkg::CMD_QUERY;
                else
                    cmd = cde_pkg::CMD_W'($urandom_range(cde_pkg::CMD_QUERY + 1,
                                                         CMD_CODE_MAX));
                queue_op(cmd, pick_word(), i == 0 && $urandom_range(0, 3) == 0);
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() > 0 || expected_views.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("PASS circular_deque_engine");
        else
            $display("FAIL circular_deque_engine");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("FAIL circular_deque_engine");
        $finish;
    end

endmodule
